FILE: rtl/core/sqltok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqltok_pkg
// Shared types and constants for the SQL statement tokenizer.
// ----------------------------------------------------------------------------
package sqltok_pkg;

  // Default width of the character position counter
  localparam int OFFSET_BITS_DEFAULT = 16;

  // Result queue depth; two free slots are needed to take an item
  localparam int QDEPTH = 4;

  // Number of keyword letters compared
  localparam int KW_LEN = 6;

  // Token kinds as reported on token_kind
  typedef enum logic [2:0] {
    TK_SELECT = 3'd0,
    TK_INSERT = 3'd1,
    TK_COLVAL = 3'd2,
    TK_SEP    = 3'd3,
    TK_END    = 3'd4,
    TK_ERR    = 3'd5
  } token_kind_t;

  // Tokenizer phase
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_KEYWORD = 3'd1,
    PH_BETWEEN = 3'd2,
    PH_COLVAL  = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  // Keyword flag bits: select, SELECT, insert, INSERT
  localparam int KF_SEL_LO = 0;
  localparam int KF_SEL_UP = 1;
  localparam int KF_INS_LO = 2;
  localparam int KF_INS_UP = 3;

  // Special characters
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Lower-case keyword spellings
  localparam logic [7:0] KW_SEL [KW_LEN] = '{8'h73, 8'h65, 8'h6C, 8'h65, 8'h63, 8'h74};
  localparam logic [7:0] KW_INS [KW_LEN] = '{8'h69, 8'h6E, 8'h73, 8'h65, 8'h72, 8'h74};

  // One queued result item
  typedef struct packed {
    token_kind_t kind;
    logic [15:0] offset;
    logic [15:0] len;
    logic        last;
  } result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_colval(input logic [7:0] c);
    return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DASH);
  endfunction

endpackage

FILE: rtl/core/sql_statement_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_statement_tokenizer
// Character-at-a-time tokenizer for simple SELECT / INSERT statements.
// ----------------------------------------------------------------------------
// Feed one character per item, with byte 0 ending the statement. Each item
// is decided in the cycle it is accepted: the phase, position and keyword
// flags update at once and the zero, one or two tokens it causes go into a
// four-entry result queue. A new item is taken in every cycle while the
// queue has two free slots, so the input runs at one character per cycle
// as long as the consumer takes at least one token per cycle; items that
// close a run and emit a second token grow the queue and can stall input.
// Token offsets and lengths saturate at 65535; the position counter
// saturates at 2^OFFSET_BITS - 1. After an error, input is dropped without
// results up to the end byte, which silently returns to statement start.
// ----------------------------------------------------------------------------
module sql_statement_tokenizer #(
  parameter int OFFSET_BITS = sqltok_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               char_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sqltok_pkg::token_kind_t  token_kind,
  output logic [15:0]              token_offset,
  output logic [15:0]              token_len,
  output logic                     last_of_run
);
  import sqltok_pkg::*;

  localparam int QPTR = $clog2(QDEPTH);
  localparam int QCNT = $clog2(QDEPTH + 1);
  localparam int KWIDX = $clog2(KW_LEN + 1);

  // Saturate a position-wide value to the 16-bit report width
  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    if (v > OFFSET_BITS'(17'hFFFF)) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  // Tokenizer state
  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] position, position_next;
  logic [OFFSET_BITS-1:0] run_start, run_start_next;
  logic [3:0]             keyword_flags, keyword_flags_next;
  logic [KWIDX-1:0]       letters_seen, letters_seen_next;
  logic                   gap_skipped, gap_skipped_next;

  // Result queue
  result_t          queue_mem [QDEPTH];
  logic [QPTR-1:0]  head, tail;
  logic [QCNT-1:0]  count;

  logic accept, pop;
  logic emit_a, emit_b, do_btw, gap_in, restart;
  result_t res_a, res_b, push0, push1;
  logic [1:0] n_push;

  // Keyword compare helpers
  logic [KWIDX-1:0] kw_idx;
  logic [3:0]       kw_base;
  logic [3:0]       kw_flags;
  logic [KWIDX-1:0] kw_letters;
  logic [7:0]       kw_s, kw_i;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;
  assign in_ready  = (count <= QCNT'(QDEPTH - 2));
  assign out_valid = (count != '0);

  // Compare one keyword letter against both spellings of both keywords
  always_comb begin
    kw_idx  = (phase == PH_START) ? '0 : letters_seen;
    kw_base = (phase == PH_START) ? 4'hF : keyword_flags;
    kw_flags   = kw_base;
    kw_letters = kw_idx;
    kw_s = 8'h00;
    kw_i = 8'h00;
    if (kw_idx < KWIDX'(KW_LEN)) begin
      kw_s = KW_SEL[kw_idx[$clog2(KW_LEN)-1:0]];
      kw_i = KW_INS[kw_idx[$clog2(KW_LEN)-1:0]];
      if (char_in != kw_s)            kw_flags[KF_SEL_LO] = 1'b0;
      if (char_in != kw_s - CASE_GAP) kw_flags[KF_SEL_UP] = 1'b0;
      if (char_in != kw_i)            kw_flags[KF_INS_LO] = 1'b0;
      if (char_in != kw_i - CASE_GAP) kw_flags[KF_INS_UP] = 1'b0;
      kw_letters = kw_idx + KWIDX'(1);
    end
  end

  // Decide the tokens and next state for the current character
  always_comb begin
    phase_next         = phase;
    run_start_next     = run_start;
    keyword_flags_next = keyword_flags;
    letters_seen_next  = letters_seen;
    gap_skipped_next   = gap_skipped;
    position_next      = position;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    do_btw  = 1'b0;
    gap_in  = gap_skipped;
    restart = 1'b0;
    res_a = '{kind: TK_ERR, offset: sat16(position), len: 16'd0, last: 1'b0};
    res_b = '{kind: TK_ERR, offset: sat16(position), len: 16'd0, last: 1'b0};

    case (phase)
      PH_START: begin
        if (is_letter(char_in)) begin
          run_start_next     = position;
          keyword_flags_next = kw_flags;
          letters_seen_next  = kw_letters;
          phase_next         = PH_KEYWORD;
        end else begin
          emit_a = 1'b1;
          if (char_in == CH_END) restart = 1'b1;
          else phase_next = PH_ERROR;
        end
      end
      PH_KEYWORD: begin
        if (is_letter(char_in)) begin
          keyword_flags_next = kw_flags;
          letters_seen_next  = kw_letters;
        end else if (letters_seen >= KWIDX'(KW_LEN) && keyword_flags != 4'h0) begin
          emit_a       = 1'b1;
          res_a.kind   = (keyword_flags[KF_SEL_UP:KF_SEL_LO] != 2'b00) ? TK_SELECT : TK_INSERT;
          res_a.offset = sat16(run_start);
          res_a.len    = sat16(position - run_start);
          do_btw       = 1'b1;
          gap_in       = 1'b0;
        end else begin
          emit_a       = 1'b1;
          res_a.offset = sat16(run_start);
          if (char_in == CH_END) restart = 1'b1;
          else phase_next = PH_ERROR;
        end
      end
      PH_BETWEEN: begin
        do_btw = 1'b1;
      end
      PH_COLVAL: begin
        if (!is_colval(char_in)) begin
          emit_a       = 1'b1;
          res_a.kind   = TK_COLVAL;
          res_a.offset = sat16(run_start);
          res_a.len    = sat16(position - run_start);
          do_btw       = 1'b1;
          gap_in       = 1'b0;
        end
      end
      default: begin
        if (char_in == CH_END) restart = 1'b1;
      end
    endcase

    // Handle the character that follows a finished token
    if (do_btw) begin
      if (!gap_in && char_in == CH_END) begin
        emit_b     = 1'b1;
        res_b.kind = TK_END;
        restart    = 1'b1;
      end else if (!gap_in && (char_in == CH_SPACE || char_in == CH_COMMA)) begin
        gap_skipped_next = 1'b1;
        phase_next       = PH_BETWEEN;
      end else begin
        gap_skipped_next = 1'b0;
        if (is_colval(char_in)) begin
          run_start_next = position;
          phase_next     = PH_COLVAL;
        end else if (char_in == CH_SEMI) begin
          emit_b     = 1'b1;
          res_b.kind = TK_SEP;
          res_b.len  = 16'd1;
          phase_next = PH_BETWEEN;
        end else begin
          emit_b = 1'b1;
          if (char_in == CH_END) restart = 1'b1;
          else phase_next = PH_ERROR;
        end
      end
    end

    // Return to statement start or advance the position
    if (restart) begin
      phase_next         = PH_START;
      position_next      = '0;
      run_start_next     = '0;
      keyword_flags_next = 4'hF;
      letters_seen_next  = '0;
      gap_skipped_next   = 1'b0;
    end else if (position != '1) begin
      position_next = position + OFFSET_BITS'(1);
    end
  end

  // Order the results and mark the final one of this item
  always_comb begin
    push0 = emit_a ? res_a : res_b;
    push1 = res_b;
    n_push = 2'(emit_a) + 2'(emit_b);
    push0.last = (n_push == 2'd1);
    push1.last = 1'b1;
  end

  // Hold the tokenizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      position      <= '0;
      run_start     <= '0;
      keyword_flags <= 4'hF;
      letters_seen  <= '0;
      gap_skipped   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      position      <= position_next;
      run_start     <= run_start_next;
      keyword_flags <= keyword_flags_next;
      letters_seen  <= letters_seen_next;
      gap_skipped   <= gap_skipped_next;
    end
  end

  // Advance the queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + QPTR'(1);
      if (accept) tail <= tail + QPTR'(n_push);
      count <= count + (accept ? QCNT'(n_push) : QCNT'(0)) - QCNT'(pop);
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (accept && n_push != 2'd0) queue_mem[tail] <= push0;
    if (accept && n_push == 2'd2) queue_mem[tail + QPTR'(1)] <= push1;
  end

  assign token_kind   = queue_mem[head].kind;
  assign token_offset = queue_mem[head].offset;
  assign token_len    = queue_mem[head].len;
  assign last_of_run  = queue_mem[head].last;

endmodule

FILE: rtl/core/sqltok_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqltok_checker
// Port-level checks for the SQL statement tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module sqltok_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [7:0]              char_in,
  input logic                    out_valid,
  input logic                    out_ready,
  input sqltok_pkg::token_kind_t token_kind,
  input logic [15:0]             token_offset,
  input logic [15:0]             token_len,
  input logic                    last_of_run
);
  import sqltok_pkg::*;

  // A stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
      $stable(token_offset) && $stable(token_len) && $stable(last_of_run))
    else $error("stalled result item changed");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item present after reset");

  // End and error tokens carry no length
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == TK_END || token_kind == TK_ERR) |-> token_len == 16'd0)
    else $error("end or error item with nonzero length");

  // A separator is one character
  a_sep_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_SEP |-> token_len == 16'd1 && last_of_run)
    else $error("separator item malformed");

  // The end token is always the final token of its character
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_END |-> last_of_run)
    else $error("end item not marked last");

endmodule

bind sql_statement_tokenizer sqltok_checker u_sqltok_checker (.*);
